[sv/prac_pkg.sv]
// shared constants, lookup tables and request/result types for the point rotation block
package prac_pkg;

  localparam int unsigned COORD_WIDTH      = 24;
  localparam int unsigned ANGLE_WIDTH      = 16;
  localparam int unsigned ANGLE_ITERATIONS = 16;
  localparam int unsigned CORDIC_MAX_STEPS = 24;
  localparam int unsigned CORDIC_STEPS     =
      (ANGLE_ITERATIONS < CORDIC_MAX_STEPS) ? ANGLE_ITERATIONS : CORDIC_MAX_STEPS;

  localparam int unsigned CORDIC_WIDTH = 32;
  localparam int unsigned TRIG_WIDTH   = 17;
  localparam int unsigned FRAC_SHIFT   = 15;
  localparam int          ROUND_HALF   = 1 << (FRAC_SHIFT - 1);
  localparam int          TRIG_ONE     = 32768;
  localparam int          INV_GAIN     = 652032874;
  localparam int          QUARTER_TURN = 1 << (CORDIC_WIDTH - 2);

  localparam logic [CORDIC_WIDTH-1:0] ATAN_TURNS [CORDIC_MAX_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] pivot_x;
    logic signed [COORD_WIDTH-1:0] pivot_y;
    logic        [ANGLE_WIDTH-1:0] turn_angle;
  } prac_req_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
  } prac_result_t;

endpackage

[sv/point_rotate_about_center.sv]
// point rotation about a pivot: pipelined cordic sine/cosine, multiply and saturating output
//
// A request is taken on every clock cycle in which start is high; busy never rises, so a
// new point can enter each cycle. The angle runs through a fully pipelined cordic with one
// iteration per stage (16 stages), followed by a sine/cosine rounding stage, a multiply
// stage and a rounding/saturating output stage. The rotated point appears on result_o with
// result_valid_o high for one cycle, once its request has passed the input register, the
// cordic stages and the rounding, multiply and output stages. Results leave in request
// order and must be taken in the cycle they are shown; nothing holds them back.
module point_rotate_about_center (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  prac_pkg::prac_req_t    req_i,
  output logic                   busy,
  output logic                   result_valid_o,
  output prac_pkg::prac_result_t result_o
);

  localparam int unsigned Steps = prac_pkg::CORDIC_STEPS;
  localparam int unsigned CW    = prac_pkg::COORD_WIDTH;
  localparam int unsigned AW    = prac_pkg::ANGLE_WIDTH;
  localparam int unsigned KW    = prac_pkg::CORDIC_WIDTH;
  localparam int unsigned TW    = prac_pkg::TRIG_WIDTH;
  localparam int unsigned FS    = prac_pkg::FRAC_SHIFT;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned PW    = DW + TW;
  localparam int unsigned SW    = PW + 1 - FS;
  localparam int unsigned RW    = SW + 1;
  localparam int unsigned TRW   = KW + 1 - FS;
  localparam longint      CMax  = (longint'(1) << (CW - 1)) - 1;
  localparam longint      CMin  = -CMax - 1;

  // angle fold into [-1/4, +1/4] turn
  logic                 fold;
  logic signed [KW-1:0] z_init;

  assign fold = (!req_i.turn_angle[AW-1] &&
                 (req_i.turn_angle > {2'b01, {(AW-2){1'b0}}})) ||
                (req_i.turn_angle[AW-1] &&
                 (req_i.turn_angle < {2'b11, {(AW-2){1'b0}}}));
  assign z_init = {req_i.turn_angle[AW-1] ^ fold, req_i.turn_angle[AW-2:0],
                   {(KW-AW){1'b0}}};

  // cordic pipeline, index 0 is the input register
  logic [Steps:0]       cv_q;
  logic [Steps:0]       flip_q;
  logic signed [KW-1:0] cx_q [Steps+1];
  logic signed [KW-1:0] cy_q [Steps+1];
  logic signed [KW-1:0] cz_q [Steps+1];
  logic signed [DW-1:0] dx_q [Steps+1];
  logic signed [DW-1:0] dy_q [Steps+1];
  logic signed [CW-1:0] qx_q [Steps+1];
  logic signed [CW-1:0] qy_q [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q[0]   <= KW'(prac_pkg::INV_GAIN);
    cy_q[0]   <= '0;
    cz_q[0]   <= z_init;
    flip_q[0] <= fold;
    dx_q[0]   <= DW'(req_i.point_x) - DW'(req_i.pivot_x);
    dy_q[0]   <= DW'(req_i.point_y) - DW'(req_i.pivot_y);
    qx_q[0]   <= req_i.pivot_x;
    qy_q[0]   <= req_i.pivot_y;
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_stage
    logic signed [KW-1:0] xs;
    logic signed [KW-1:0] ys;
    logic signed [KW-1:0] at;

    assign xs = cx_q[k-1] >>> (k - 1);
    assign ys = cy_q[k-1] >>> (k - 1);
    assign at = signed'(prac_pkg::ATAN_TURNS[k-1]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k] <= 1'b0;
      end else begin
        cv_q[k] <= cv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!cz_q[k-1][KW-1]) begin
        cx_q[k] <= cx_q[k-1] - ys;
        cy_q[k] <= cy_q[k-1] + xs;
        cz_q[k] <= cz_q[k-1] - at;
      end else begin
        cx_q[k] <= cx_q[k-1] + ys;
        cy_q[k] <= cy_q[k-1] - xs;
        cz_q[k] <= cz_q[k-1] + at;
      end
      flip_q[k] <= flip_q[k-1];
      dx_q[k]   <= dx_q[k-1];
      dy_q[k]   <= dy_q[k-1];
      qx_q[k]   <= qx_q[k-1];
      qy_q[k]   <= qy_q[k-1];
    end
  end

  // sine/cosine rounding to q2.15
  logic signed [KW:0]   cos_full;
  logic signed [KW:0]   sin_full;
  logic signed [KW:0]   cos_sum;
  logic signed [KW:0]   sin_sum;
  logic signed [TRW-1:0] cos_rnd;
  logic signed [TRW-1:0] sin_rnd;
  logic signed [TW-1:0] cos_d;
  logic signed [TW-1:0] sin_d;

  assign cos_full = flip_q[Steps] ? -(KW+1)'(cx_q[Steps]) : (KW+1)'(cx_q[Steps]);
  assign sin_full = flip_q[Steps] ? -(KW+1)'(cy_q[Steps]) : (KW+1)'(cy_q[Steps]);
  assign cos_sum  = cos_full + (KW+1)'(prac_pkg::ROUND_HALF);
  assign sin_sum  = sin_full + (KW+1)'(prac_pkg::ROUND_HALF);
  assign cos_rnd  = TRW'(cos_sum >>> FS);
  assign sin_rnd  = TRW'(sin_sum >>> FS);

  always_comb begin
    if (cos_rnd > TRW'(prac_pkg::TRIG_ONE)) begin
      cos_d = TW'(prac_pkg::TRIG_ONE);
    end else if (cos_rnd < -TRW'(prac_pkg::TRIG_ONE)) begin
      cos_d = -TW'(prac_pkg::TRIG_ONE);
    end else begin
      cos_d = TW'(cos_rnd);
    end
    if (sin_rnd > TRW'(prac_pkg::TRIG_ONE)) begin
      sin_d = TW'(prac_pkg::TRIG_ONE);
    end else if (sin_rnd < -TRW'(prac_pkg::TRIG_ONE)) begin
      sin_d = -TW'(prac_pkg::TRIG_ONE);
    end else begin
      sin_d = TW'(sin_rnd);
    end
  end

  logic                 tv_q;
  logic signed [TW-1:0] cos_q;
  logic signed [TW-1:0] sin_q;
  logic signed [DW-1:0] tdx_q;
  logic signed [DW-1:0] tdy_q;
  logic signed [CW-1:0] tqx_q;
  logic signed [CW-1:0] tqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else begin
      tv_q <= cv_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
    sin_q <= sin_d;
    tdx_q <= dx_q[Steps];
    tdy_q <= dy_q[Steps];
    tqx_q <= qx_q[Steps];
    tqy_q <= qy_q[Steps];
  end

  // products
  logic                 mv_q;
  logic signed [PW-1:0] dxc_q;
  logic signed [PW-1:0] dys_q;
  logic signed [PW-1:0] dxs_q;
  logic signed [PW-1:0] dyc_q;
  logic signed [CW-1:0] mqx_q;
  logic signed [CW-1:0] mqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= tv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dxc_q <= PW'(tdx_q) * PW'(cos_q);
    dys_q <= PW'(tdy_q) * PW'(sin_q);
    dxs_q <= PW'(tdx_q) * PW'(sin_q);
    dyc_q <= PW'(tdy_q) * PW'(cos_q);
    mqx_q <= tqx_q;
    mqy_q <= tqy_q;
  end

  // round, add pivot back, saturate
  logic signed [PW:0]   sum_x;
  logic signed [PW:0]   sum_y;
  logic signed [RW-1:0] rx;
  logic signed [RW-1:0] ry;
  prac_pkg::prac_result_t result_d;

  assign sum_x = (PW+1)'(dxc_q) - (PW+1)'(dys_q) + (PW+1)'(prac_pkg::ROUND_HALF);
  assign sum_y = (PW+1)'(dxs_q) + (PW+1)'(dyc_q) + (PW+1)'(prac_pkg::ROUND_HALF);
  assign rx    = RW'(SW'(sum_x >>> FS)) + RW'(mqx_q);
  assign ry    = RW'(SW'(sum_y >>> FS)) + RW'(mqy_q);

  always_comb begin
    if (rx > RW'(CMax)) begin
      result_d.rotated_x = CW'(CMax);
    end else if (rx < RW'(CMin)) begin
      result_d.rotated_x = CW'(CMin);
    end else begin
      result_d.rotated_x = CW'(rx);
    end
    if (ry > RW'(CMax)) begin
      result_d.rotated_y = CW'(CMax);
    end else if (ry < RW'(CMin)) begin
      result_d.rotated_y = CW'(CMin);
    end else begin
      result_d.rotated_y = CW'(ry);
    end
  end

  logic                   result_valid_q;
  prac_pkg::prac_result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign busy           = 1'b0;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // every request produces its result after the fixed pipeline depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(Steps + 4) result_valid_o)
    else $error("request did not produce a result at the pipeline depth");

  // no result without a request entering the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(cv_q[0], Steps + 3))
    else $error("result strobe without a matching request");

  // folded angle lies within a quarter turn either way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q[0] |-> (cz_q[0] <= KW'(prac_pkg::QUARTER_TURN)) &&
                (cz_q[0] >= -KW'(prac_pkg::QUARTER_TURN)))
    else $error("angle fold left the cordic convergence range");

endmodule
